// ===== hdl/binary_to_decimal_ascii_assert.svh =====
// Assertion macros for the binary_to_decimal_ascii block.
// Both sample on clock and are disabled while reset is high.
`ifndef BINARY_TO_DECIMAL_ASCII_ASSERT_SVH
`define BINARY_TO_DECIMAL_ASCII_ASSERT_SVH

// Same-cycle implication.
`define B2DA_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define B2DA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/b2da_pkg.sv =====
package b2da_pkg;

   localparam int MAX_DIGITS = 10;
   localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
   localparam int IDX_W      = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

   localparam logic [31:0] RECIP_10   = 32'hCCCC_CCCD;  // ceil(2^35 / 10)
   localparam int          RECIP_SHFT = 35;

   localparam logic [7:0] ASCII_ZERO  = 8'h30;
   localparam logic [7:0] ASCII_MINUS = 8'h2D;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_SIGN,
      ST_DIGIT
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;       // capture a new word
      logic step;       // peel off one decimal digit
      logic pop;        // drop the digit just sent
      logic sel_sign;   // drive '-' on the output
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic mag_zero;
      logic buf_full;
      logic neg;
      logic last_digit; // the digit on the output is the final one
   } sts_type;

endpackage

// ===== hdl/b2da_dp.sv =====
module b2da_dp import b2da_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output sts_type     sts,
   input  logic        op,
   input  logic [31:0] value,
   output logic [7:0]  character,
   output logic        last
);

   logic [31:0]      mag_ff, mag_in;
   logic             neg_ff, neg_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [3:0]       dig_ff [MAX_DIGITS];

   logic [63:0]      prod;
   logic [28:0]      quot;
   logic [31:0]      quot_ext;
   logic [31:0]      quot_x10;
   logic [31:0]      rem_full;
   logic [3:0]       rem;
   logic [CNT_W-1:0] rd_ptr;
   logic [3:0]       rd_digit;

   // divide by ten via reciprocal multiply, exact for all 32-bit values
   assign prod     = {32'b0, mag_ff} * {32'b0, RECIP_10};
   assign quot     = prod[63:RECIP_SHFT];
   assign quot_ext = {3'b0, quot};
   assign quot_x10 = (quot_ext << 3) + (quot_ext << 1);
   assign rem_full = mag_ff - quot_x10;
   assign rem      = rem_full[3:0];

   assign rd_ptr   = cnt_ff - CNT_W'(1);
   assign rd_digit = dig_ff[rd_ptr[IDX_W-1:0]];

   always_comb begin
      mag_in = mag_ff;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      if (cmd.load) begin
         neg_in = op & value[31];
         mag_in = (op & value[31]) ? (32'd0 - value) : value;
         cnt_in = '0;
      end else if (cmd.step) begin
         mag_in = quot_ext;
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (cmd.pop && (cnt_ff != '0)) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      neg_ff <= neg_in;
      if (cmd.step) begin
         dig_ff[cnt_ff[IDX_W-1:0]] <= rem;
      end
   end

   assign sts.mag_zero   = (mag_ff == 32'd0);
   assign sts.buf_full   = (cnt_ff == CNT_W'(MAX_DIGITS));
   assign sts.neg        = neg_ff;
   assign sts.last_digit = (cnt_ff <= CNT_W'(1));

   // an empty buffer means the value was zero: send a lone '0'
   always_comb begin
      if (cmd.sel_sign) begin
         character = ASCII_MINUS;
         last      = 1'b0;
      end else if (cnt_ff == '0) begin
         character = ASCII_ZERO;
         last      = 1'b1;
      end else begin
         character = ASCII_ZERO + {4'b0, rd_digit};
         last      = (cnt_ff == CNT_W'(1));
      end
   end

endmodule

// ===== hdl/b2da_ctrl.sv =====
module b2da_ctrl import b2da_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   input  sts_type sts,
   output cmd_type cmd
);

   `include "binary_to_decimal_ascii_assert.svh"

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_CONV;
         end
         ST_CONV: begin
            if (sts.mag_zero || sts.buf_full) begin
               state_in = sts.neg ? ST_SIGN : ST_DIGIT;
            end
         end
         ST_SIGN: begin
            if (rsp_tready) state_in = ST_DIGIT;
         end
         ST_DIGIT: begin
            if (rsp_tready && sts.last_digit) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready   = 1'b0;
      rsp_tvalid   = 1'b0;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_CONV: begin
            cmd.step = !sts.mag_zero && !sts.buf_full;
         end
         ST_SIGN: begin
            rsp_tvalid   = 1'b1;
            cmd.sel_sign = 1'b1;
         end
         ST_DIGIT: begin
            rsp_tvalid = 1'b1;
            cmd.pop    = rsp_tready;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   `B2DA_ASSERT_NOW(a_one_side, rsp_tvalid, !req_tready, "input taken while output busy")
   `B2DA_ASSERT_NEXT(a_load_conv, req_tvalid && req_tready, state_ff == ST_CONV,
      "accepted word did not start conversion")
   `B2DA_ASSERT_NEXT(a_last_idle, (state_ff == ST_DIGIT) && rsp_tready && sts.last_digit,
      state_ff == ST_IDLE, "final character did not end the word")
   `B2DA_ASSERT_NEXT(a_full_stop, (state_ff == ST_CONV) && sts.buf_full,
      state_ff != ST_CONV, "conversion ran past a full digit buffer")

endmodule

// ===== hdl/binary_to_decimal_ascii.sv =====
// Binary to decimal ASCII converter.
// Input stream (req_): tdata carries the 32-bit value, tuser selects
// unsigned (0) or signed two's complement (1). Output stream (rsp_): one
// ASCII character per word in tdata, most significant digit first, a
// leading '-' for negative signed values; tlast marks the final character.
// Zero gives a single '0'.
// Timing: after a word is accepted, one digit is produced per cycle by a
// divide-by-ten unit (reciprocal multiply), then characters leave at one
// per cycle while rsp_tready is high.
// One word is in flight at a time: req_tready is high only when idle.
// If the receiver stalls, the current character holds on rsp_tdata and the
// block waits. Reset returns the controller to idle and drops any word
// being converted; no results are pending after reset.
module binary_to_decimal_ascii import b2da_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // value[31:0]
   input  logic        req_tuser,   // op (1 = signed)
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // character[7:0]
   output logic        rsp_tlast
);

   cmd_type cmd;
   sts_type sts;

   b2da_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   b2da_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .op        (req_tuser),
      .value     (req_tdata),
      .character (rsp_tdata),
      .last      (rsp_tlast)
   );

endmodule
